[hw/rtl/v3alu_pkg.sv]
// ----------------------------------------------------------------------------
// v3alu_pkg
// Opcodes and flag types shared by the vector ALU and its arithmetic units.
// ----------------------------------------------------------------------------
package v3alu_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_SCALE    = 4'd3,
    OP_DIV      = 4'd4,
    OP_DIVS     = 4'd5,
    OP_DOT      = 4'd6,
    OP_CROSS    = 4'd7,
    OP_NORM     = 4'd8,
    OP_SETLEN   = 4'd9,
    OP_EQ       = 4'd10,
    OP_NE       = 4'd11,
    OP_PAR_SC   = 4'd12,
    OP_PERP_SC  = 4'd13,
    OP_PAR_VEC  = 4'd14,
    OP_PERP_VEC = 4'd15
  } op_t;

  typedef struct packed {
    logic ov;
    logic dz;
  } flags_t;

endpackage

[hw/rtl/vector3_fixed_point_alu.sv]
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu
// Three-component signed fixed-point vector ALU, fully pipelined.
//
// Channel | Ports                       | Transfer
// input   | in_op .. in_scalar_in       | start high while busy is low
// result  | out_rx .. out_overflow      | out_valid high for one cycle
//
// One transaction per cycle.
// The depth is set by the square root pipeline (one bit per stage) followed
// by the divider pipeline (one quotient bit per stage).
// busy stays low; reset clears only the valid bits of the pipeline.
// Results leave on the strobe and are never held back.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  v3alu_pkg::op_t              in_op,
  input  logic signed [WORD_BITS-1:0] in_ax,
  input  logic signed [WORD_BITS-1:0] in_ay,
  input  logic signed [WORD_BITS-1:0] in_az,
  input  logic signed [WORD_BITS-1:0] in_bx,
  input  logic signed [WORD_BITS-1:0] in_by_comp,
  input  logic signed [WORD_BITS-1:0] in_bz,
  input  logic signed [WORD_BITS-1:0] in_scalar_in,
  output logic                        out_valid,
  output logic signed [WORD_BITS-1:0] out_rx,
  output logic signed [WORD_BITS-1:0] out_ry,
  output logic signed [WORD_BITS-1:0] out_rz,
  output logic signed [WORD_BITS-1:0] out_scalar_out,
  output logic                        out_compare_flag,
  output logic                        out_div_zero,
  output logic                        out_overflow
);

  import v3alu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int P  = 2 * W;
  localparam int PS = 2 * W + 2;
  localparam int LD = W + F + 2;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};

  typedef logic [2:0][W-1:0] vec_t;

  typedef struct packed {
    op_t          op;
    vec_t         a;
    vec_t         b;
    logic [W-1:0] s;
    logic         bz;
    logic [W-1:0] dot;
    logic         dot_ov;
    vec_t         t;
    logic         t_ov;
  } sb_t;

  typedef struct packed {
    sb_t          sb;
    logic [W-1:0] nx;
    logic         nx_ov;
    logic         nb_ov;
  } sb2_t;

  function automatic logic signed [PS-1:0] ext_p(input logic [P-1:0] v);
    return {{(PS-P){v[P-1]}}, v};
  endfunction

  function automatic logic signed [PS-1:0] ext_w(input logic [W-1:0] v);
    return {{(PS-W){v[W-1]}}, v};
  endfunction

  // Returns {overflow, saturated word}.
  function automatic logic [W:0] sat_fn(input logic signed [PS-1:0] v);
    logic [PS-W:0] top;
    top = v[PS-1:W-1];
    if ((top == '0) || (top == '1)) begin
      return {1'b0, v[W-1:0]};
    end else if (v[PS-1]) begin
      return {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b1, WMAX};
    end
  endfunction

  // ---------------- Stage 1: cross and dot products ----------------
  logic            acc;
  logic            v1_r;
  op_t             op1_r;
  vec_t            a1_r, b1_r;
  logic [W-1:0]    s1_r;
  logic            bz1_r;
  logic [P-1:0]    pr_nxt [9];
  logic [P-1:0]    pr1_r  [9];

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  assign pr_nxt[0] = in_ax * in_bx;
  assign pr_nxt[1] = in_ay * in_by_comp;
  assign pr_nxt[2] = in_az * in_bz;
  assign pr_nxt[3] = in_ay * in_bz;
  assign pr_nxt[4] = in_az * in_by_comp;
  assign pr_nxt[5] = in_az * in_bx;
  assign pr_nxt[6] = in_ax * in_bz;
  assign pr_nxt[7] = in_ax * in_by_comp;
  assign pr_nxt[8] = in_ay * in_bx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    op1_r <= in_op;
    a1_r  <= {in_az, in_ay, in_ax};
    b1_r  <= {in_bz, in_by_comp, in_bx};
    s1_r  <= in_scalar_in;
    bz1_r <= (in_bx == '0) && (in_by_comp == '0) && (in_bz == '0);
    for (int i = 0; i < 9; i++) begin
      pr1_r[i] <= pr_nxt[i];
    end
  end

  // ---------------- Stage 2: dot and cross rounding ----------------
  logic v2_r;
  sb_t  sb2_nxt, sb2_r;

  always_comb begin
    logic [W:0] dsat;
    logic [W:0] csat [3];
    sb2_nxt.op = op1_r;
    sb2_nxt.a  = a1_r;
    sb2_nxt.b  = b1_r;
    sb2_nxt.s  = s1_r;
    sb2_nxt.bz = bz1_r;
    dsat = sat_fn((ext_p(pr1_r[0]) + ext_p(pr1_r[1]) + ext_p(pr1_r[2])) >>> F);
    csat[0] = sat_fn((ext_p(pr1_r[3]) - ext_p(pr1_r[4])) >>> F);
    csat[1] = sat_fn((ext_p(pr1_r[5]) - ext_p(pr1_r[6])) >>> F);
    csat[2] = sat_fn((ext_p(pr1_r[7]) - ext_p(pr1_r[8])) >>> F);
    sb2_nxt.dot    = dsat[W-1:0];
    sb2_nxt.dot_ov = dsat[W];
    for (int i = 0; i < 3; i++) begin
      sb2_nxt.t[i] = csat[i][W-1:0];
    end
    sb2_nxt.t_ov = csat[0][W] | csat[1][W] | csat[2][W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sb2_r <= sb2_nxt;
  end

  // ---------------- Stage 3: squares for the two norms ----------------
  logic         v3_r;
  sb_t          sb3_r;
  logic [W-1:0] xsel    [3];
  logic [P-1:0] sqx_nxt [3];
  logic [P-1:0] sqb_nxt [3];
  logic [P-1:0] sqx3_r  [3];
  logic [P-1:0] sqb3_r  [3];

  // The first norm is taken of the cross product for the perpendicular
  // scalar projection and of A everywhere else.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xsel[i]    = (sb2_r.op == OP_PERP_SC) ? sb2_r.t[i] : sb2_r.a[i];
      sqx_nxt[i] = $signed(xsel[i]) * $signed(xsel[i]);
      sqb_nxt[i] = $signed(sb2_r.b[i]) * $signed(sb2_r.b[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    sb3_r <= sb2_r;
    for (int i = 0; i < 3; i++) begin
      sqx3_r[i] <= sqx_nxt[i];
      sqb3_r[i] <= sqb_nxt[i];
    end
  end

  // ---------------- Stage 4: sums of squares ----------------
  logic         v4_r;
  sb_t          sb4_r;
  logic [P-1:0] sumx4_r, sumb4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    sb4_r   <= sb3_r;
    sumx4_r <= sqx3_r[0] + sqx3_r[1] + sqx3_r[2];
    sumb4_r <= sqb3_r[0] + sqb3_r[1] + sqb3_r[2];
  end

  // ---------------- Square roots ----------------
  logic         vq;
  sb_t          sbq;
  logic [W-1:0] root_x, root_b;

  v3alu_sqrt #(.W(W)) u_sqrt_x (
    .clk    (clk),
    .rad_i  (sumx4_r),
    .root_o (root_x)
  );

  v3alu_sqrt #(.W(W)) u_sqrt_b (
    .clk    (clk),
    .rad_i  (sumb4_r),
    .root_o (root_b)
  );

  v3alu_delay #(.DW($bits(sb_t)), .DEPTH(W)) u_dly_sq (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (v4_r),
    .dat_i (sb4_r),
    .vld_o (vq),
    .dat_o (sbq)
  );

  // ---------------- Divider operands ----------------
  sb2_t         sbd_nxt;
  logic [W-1:0] nb;
  logic [W-1:0] sn, sd;
  logic [W-1:0] en [3];
  logic [W-1:0] ed [3];

  always_comb begin
    sbd_nxt.sb    = sbq;
    sbd_nxt.nx    = root_x[W-1] ? WMAX : root_x;
    sbd_nxt.nx_ov = root_x[W-1];
    sbd_nxt.nb_ov = root_b[W-1];
    nb            = root_b[W-1] ? WMAX : root_b;
    sn = sbq.dot;
    sd = nb;
    for (int i = 0; i < 3; i++) begin
      en[i] = sbq.a[i];
      ed[i] = sbq.b[i];
    end
    case (sbq.op) inside
      OP_SETLEN: begin
        sn = sbq.s;
        sd = sbd_nxt.nx;
      end
      OP_PERP_SC: begin
        sn = sbd_nxt.nx;
      end
      OP_DIVS: begin
        for (int i = 0; i < 3; i++) begin
          ed[i] = sbq.s;
        end
      end
      OP_PAR_VEC, OP_PERP_VEC: begin
        for (int i = 0; i < 3; i++) begin
          en[i] = sbq.b[i];
          ed[i] = nb;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- Dividers ----------------
  logic         vd;
  sb2_t         sbd;
  logic [W-1:0] qs;
  flags_t       fs;
  logic [W-1:0] qe [3];
  flags_t       fe [3];

  v3alu_div #(.W(W), .F(F)) u_div_s (
    .clk   (clk),
    .num_i (sn),
    .den_i (sd),
    .q_o   (qs),
    .flg_o (fs)
  );

  for (genvar g = 0; g < 3; g++) begin : g_ediv
    v3alu_div #(.W(W), .F(F)) u_div_e (
      .clk   (clk),
      .num_i (en[g]),
      .den_i (ed[g]),
      .q_o   (qe[g]),
      .flg_o (fe[g])
    );
  end

  v3alu_delay #(.DW($bits(sb2_t)), .DEPTH(LD)) u_dly_dv (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vq),
    .dat_i (sbd_nxt),
    .vld_o (vd),
    .dat_o (sbd)
  );

  // ---------------- Stage M1: final multiplies ----------------
  logic         v6_r;
  sb2_t         sb6_r;
  logic [W-1:0] qs6_r;
  flags_t       fs6_r;
  vec_t         qe6_r;
  logic         feov6_r, fedz6_r;
  logic [W-1:0] ml [3];
  logic [W-1:0] mr [3];
  logic [P-1:0] pm_nxt [3];
  logic [P-1:0] pm6_r  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ml[i] = sbd.sb.a[i];
      mr[i] = sbd.sb.b[i];
      case (sbd.sb.op) inside
        OP_SCALE:  mr[i] = sbd.sb.s;
        OP_SETLEN: mr[i] = qs;
        OP_PAR_VEC, OP_PERP_VEC: begin
          ml[i] = qe[i];
          mr[i] = qs;
        end
        default: begin
        end
      endcase
      pm_nxt[i] = $signed(ml[i]) * $signed(mr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    sb6_r   <= sbd;
    qs6_r   <= qs;
    fs6_r   <= fs;
    feov6_r <= fe[0].ov | fe[1].ov | fe[2].ov;
    fedz6_r <= fe[0].dz | fe[1].dz | fe[2].dz;
    for (int i = 0; i < 3; i++) begin
      qe6_r[i] <= qe[i];
      pm6_r[i] <= pm_nxt[i];
    end
  end

  // ---------------- Stage M2: product rounding ----------------
  logic         v7_r;
  sb2_t         sb7_r;
  logic [W-1:0] qs7_r;
  flags_t       fs7_r;
  vec_t         qe7_r;
  logic         feov7_r, fedz7_r;
  vec_t         mr_nxt, mr7_r;
  logic         mov_nxt, mov7_r;

  always_comb begin
    logic [W:0] ms [3];
    mov_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ms[i]     = sat_fn(ext_p(pm6_r[i]) >>> F);
      mr_nxt[i] = ms[i][W-1:0];
      mov_nxt   = mov_nxt | ms[i][W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    sb7_r   <= sb6_r;
    qs7_r   <= qs6_r;
    fs7_r   <= fs6_r;
    qe7_r   <= qe6_r;
    feov7_r <= feov6_r;
    fedz7_r <= fedz6_r;
    mr7_r   <= mr_nxt;
    mov7_r  <= mov_nxt;
  end

  // ---------------- Stage M3: result selection ----------------
  vec_t         add_v, sub_v, prj_v;
  logic         add_ov, sub_ov, prj_ov;
  logic         eq;
  logic         chain_ov;
  vec_t         r_nxt;
  logic [W-1:0] sc_nxt;
  logic         cmp_nxt, dz_nxt, ov_nxt;

  logic         vo_r;
  vec_t         res_r;
  logic [W-1:0] sc_r;
  logic         cmp_r, dz_r, ov_r;

  always_comb begin
    logic [W:0] sa [3];
    logic [W:0] ss [3];
    logic [W:0] sp [3];
    add_ov = 1'b0;
    sub_ov = 1'b0;
    prj_ov = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sa[i]    = sat_fn(ext_w(sb7_r.sb.a[i]) + ext_w(sb7_r.sb.b[i]));
      ss[i]    = sat_fn(ext_w(sb7_r.sb.a[i]) - ext_w(sb7_r.sb.b[i]));
      sp[i]    = sat_fn(ext_w(sb7_r.sb.a[i]) - ext_w(mr7_r[i]));
      add_v[i] = sa[i][W-1:0];
      sub_v[i] = ss[i][W-1:0];
      prj_v[i] = sp[i][W-1:0];
      add_ov   = add_ov | sa[i][W];
      sub_ov   = sub_ov | ss[i][W];
      prj_ov   = prj_ov | sp[i][W];
    end
  end

  assign eq       = (sb7_r.sb.a == sb7_r.sb.b);
  assign chain_ov = sb7_r.nb_ov | sb7_r.sb.dot_ov | fs7_r.ov | feov7_r | mov7_r;

  always_comb begin
    r_nxt   = '0;
    sc_nxt  = '0;
    cmp_nxt = 1'b0;
    dz_nxt  = 1'b0;
    ov_nxt  = 1'b0;
    unique case (sb7_r.sb.op)
      OP_ADD: begin
        r_nxt  = add_v;
        ov_nxt = add_ov;
      end
      OP_SUB: begin
        r_nxt  = sub_v;
        ov_nxt = sub_ov;
      end
      OP_MUL, OP_SCALE: begin
        r_nxt  = mr7_r;
        ov_nxt = mov7_r;
      end
      OP_DIV, OP_DIVS: begin
        r_nxt  = qe7_r;
        ov_nxt = feov7_r;
        dz_nxt = fedz7_r;
      end
      OP_DOT: begin
        sc_nxt = sb7_r.sb.dot;
        ov_nxt = sb7_r.sb.dot_ov;
      end
      OP_CROSS: begin
        r_nxt  = sb7_r.sb.t;
        ov_nxt = sb7_r.sb.t_ov;
      end
      OP_NORM: begin
        sc_nxt = sb7_r.nx;
        ov_nxt = sb7_r.nx_ov;
      end
      OP_SETLEN: begin
        r_nxt  = mr7_r;
        ov_nxt = sb7_r.nx_ov | fs7_r.ov | mov7_r;
        dz_nxt = fs7_r.dz;
      end
      OP_EQ: begin
        cmp_nxt = eq;
      end
      OP_NE: begin
        cmp_nxt = ~eq;
      end
      OP_PAR_SC: begin
        if (sb7_r.sb.bz) begin
          sc_nxt = sb7_r.nx;
          ov_nxt = sb7_r.nx_ov;
        end else begin
          sc_nxt = qs7_r;
          ov_nxt = sb7_r.sb.dot_ov | sb7_r.nb_ov | fs7_r.ov;
          dz_nxt = fs7_r.dz;
        end
      end
      OP_PERP_SC: begin
        if (!sb7_r.sb.bz) begin
          sc_nxt = qs7_r;
          ov_nxt = sb7_r.sb.t_ov | sb7_r.nx_ov | sb7_r.nb_ov | fs7_r.ov;
          dz_nxt = fs7_r.dz;
        end
      end
      OP_PAR_VEC: begin
        if (sb7_r.sb.bz) begin
          r_nxt = sb7_r.sb.a;
        end else begin
          r_nxt  = mr7_r;
          ov_nxt = chain_ov;
          dz_nxt = fs7_r.dz | fedz7_r;
        end
      end
      OP_PERP_VEC: begin
        if (!sb7_r.sb.bz) begin
          r_nxt  = prj_v;
          ov_nxt = chain_ov | prj_ov;
          dz_nxt = fs7_r.dz | fedz7_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= r_nxt;
    sc_r  <= sc_nxt;
    cmp_r <= cmp_nxt;
    dz_r  <= dz_nxt;
    ov_r  <= ov_nxt;
  end

  assign out_valid        = vo_r;
  assign out_rx           = res_r[0];
  assign out_ry           = res_r[1];
  assign out_rz           = res_r[2];
  assign out_scalar_out   = sc_r;
  assign out_compare_flag = cmp_r;
  assign out_div_zero     = dz_r;
  assign out_overflow     = ov_r;

endmodule

[hw/rtl/v3alu_delay.sv]
// ----------------------------------------------------------------------------
// v3alu_delay
// Shift line that carries a valid bit and its side data alongside a pipeline.
// ----------------------------------------------------------------------------
module v3alu_delay #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  logic [DW-1:0] dat_i,
  output logic          vld_o,
  output logic [DW-1:0] dat_o
);

  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0]    dat_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r[0] <= vld_i;
      for (int i = 1; i < DEPTH; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dat_r[0] <= dat_i;
    for (int i = 1; i < DEPTH; i++) begin
      dat_r[i] <= dat_r[i-1];
    end
  end

  assign vld_o = vld_r[DEPTH-1];
  assign dat_o = dat_r[DEPTH-1];

endmodule

[hw/rtl/v3alu_sqrt.sv]
// ----------------------------------------------------------------------------
// v3alu_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module v3alu_sqrt #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic [2*W-1:0] rad_i,
  output logic [W-1:0]   root_o
);

  localparam int RW = W + 3;

  logic [RW-1:0]  rem_r  [W];
  logic [W-1:0]   root_r [W];
  logic [2*W-1:0] rad_r  [W];

  for (genvar g = 0; g < W; g++) begin : g_stage
    logic [RW-1:0]  rem_in;
    logic [W-1:0]   root_in;
    logic [2*W-1:0] rad_in;
    logic [RW-1:0]  rem_sh;
    logic [RW-1:0]  trial;
    logic           ge;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign rad_in  = rad_r[g-1];
    end

    assign rem_sh = {rem_in[RW-3:0], rad_in[2*W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      rem_r[g]  <= ge ? (rem_sh - trial) : rem_sh;
      root_r[g] <= {root_in[W-2:0], ge};
      rad_r[g]  <= {rad_in[2*W-3:0], 2'b00};
    end
  end

  assign root_o = root_r[W-1];

endmodule

[hw/rtl/v3alu_div.sv]
// ----------------------------------------------------------------------------
// v3alu_div
// Pipelined signed fixed-point divider (num << F) / den, truncated toward
// zero and saturated. One quotient bit per stage.
// ----------------------------------------------------------------------------
module v3alu_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                 clk,
  input  logic [W-1:0]         num_i,
  input  logic [W-1:0]         den_i,
  output logic [W-1:0]         q_o,
  output v3alu_pkg::flags_t    flg_o
);

  import v3alu_pkg::*;

  localparam int QB = W + F;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]  nmag;
  logic [W-1:0]  dmag;

  logic [QB-1:0] n0_r;
  logic [W-1:0]  d0_r;
  logic          neg0_r, nneg0_r, nzero0_r, dz0_r;

  logic [W-1:0]  rem_r   [QB];
  logic [QB-1:0] quo_r   [QB];
  logic [QB-1:0] n_r     [QB];
  logic [W-1:0]  d_r     [QB];
  logic          neg_r   [QB];
  logic          nneg_r  [QB];
  logic          nzero_r [QB];
  logic          dz_r    [QB];

  logic [QB-1:0] quo;
  logic          hi_any, pos_ov, neg_ov;
  logic [W-1:0]  res_r;
  flags_t        flg_r;

  assign nmag = num_i[W-1] ? (~num_i + 1'b1) : num_i;
  assign dmag = den_i[W-1] ? (~den_i + 1'b1) : den_i;

  always_ff @(posedge clk) begin
    n0_r     <= {nmag, {F{1'b0}}};
    d0_r     <= dmag;
    neg0_r   <= num_i[W-1] ^ den_i[W-1];
    nneg0_r  <= num_i[W-1];
    nzero0_r <= (num_i == '0);
    dz0_r    <= (den_i == '0);
  end

  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic [W-1:0]  rem_in;
    logic [QB-1:0] quo_in;
    logic [QB-1:0] n_in;
    logic [W-1:0]  d_in;
    logic          neg_in, nneg_in, nzero_in, dz_in;
    logic [W:0]    sh;
    logic [W:0]    df;
    logic          ge;

    if (g == 0) begin : g_first
      assign rem_in   = '0;
      assign quo_in   = '0;
      assign n_in     = n0_r;
      assign d_in     = d0_r;
      assign neg_in   = neg0_r;
      assign nneg_in  = nneg0_r;
      assign nzero_in = nzero0_r;
      assign dz_in    = dz0_r;
    end else begin : g_next
      assign rem_in   = rem_r[g-1];
      assign quo_in   = quo_r[g-1];
      assign n_in     = n_r[g-1];
      assign d_in     = d_r[g-1];
      assign neg_in   = neg_r[g-1];
      assign nneg_in  = nneg_r[g-1];
      assign nzero_in = nzero_r[g-1];
      assign dz_in    = dz_r[g-1];
    end

    assign sh = {rem_in, n_in[QB-1]};
    assign df = sh - {1'b0, d_in};
    assign ge = sh >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      rem_r[g]   <= ge ? df[W-1:0] : sh[W-1:0];
      quo_r[g]   <= {quo_in[QB-2:0], ge};
      n_r[g]     <= {n_in[QB-2:0], 1'b0};
      d_r[g]     <= d_in;
      neg_r[g]   <= neg_in;
      nneg_r[g]  <= nneg_in;
      nzero_r[g] <= nzero_in;
      dz_r[g]    <= dz_in;
    end
  end

  // A negative result may reach the most negative word; a positive one may not.
  assign quo    = quo_r[QB-1];
  assign hi_any = |quo[QB-1:W];
  assign pos_ov = hi_any | quo[W-1];
  assign neg_ov = hi_any | (quo[W-1] & (|quo[W-2:0]));

  always_ff @(posedge clk) begin
    if (dz_r[QB-1]) begin
      res_r    <= nzero_r[QB-1] ? '0 : (nneg_r[QB-1] ? MINV : MAXV);
      flg_r.ov <= 1'b0;
      flg_r.dz <= 1'b1;
    end else if (neg_r[QB-1]) begin
      res_r    <= neg_ov ? MINV : (~quo[W-1:0] + 1'b1);
      flg_r.ov <= neg_ov;
      flg_r.dz <= 1'b0;
    end else begin
      res_r    <= pos_ov ? MAXV : quo[W-1:0];
      flg_r.ov <= pos_ov;
      flg_r.dz <= 1'b0;
    end
  end

  assign q_o   = res_r;
  assign flg_o = flg_r;

endmodule

[sim/tb_vector3_fixed_point_alu.sv]
// ----------------------------------------------------------------------------
// tb_vector3_fixed_point_alu
// Self-checking testbench for the fixed-point vector ALU. A directed set of
// edge cases is followed by random operations with random gaps on the input
// side. Every accepted transaction is evaluated by a bit-accurate predictor,
// and each result strobe is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_vector3_fixed_point_alu;
  import v3alu_pkg::*;

  localparam int FRAC = 16;
  localparam int WB = 32;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 120;

  typedef logic signed [WB-1:0] word_t;
  typedef logic signed [127:0] wide_t;

  localparam wide_t W_MAX = 128'sd2147483647;
  localparam wide_t W_MIN = -128'sd2147483648;

  typedef struct {
    op_t   op;
    word_t a[3];
    word_t b[3];
    word_t s;
    bit    drain_first;
    int    gap_after;
  } vec_op_t;

  typedef struct {
    word_t r[3];
    word_t sc;
    bit    cmp;
    bit    dz;
    bit    ov;
  } alu_result_t;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  op_t   in_op;
  word_t in_ax, in_ay, in_az, in_bx, in_by_comp, in_bz, in_scalar_in;
  logic  out_valid;
  word_t out_rx, out_ry, out_rz, out_scalar_out;
  logic  out_compare_flag, out_div_zero, out_overflow;

  vec_op_t     pending_ops[$];
  alu_result_t expected_results[$];
  int          gap_left;
  int          idle_cycles;
  int          errors;
  bit          fl_ov, fl_dz;

  vector3_fixed_point_alu dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by_comp(in_by_comp), .in_bz(in_bz),
    .in_scalar_in(in_scalar_in),
    .out_valid(out_valid), .out_rx(out_rx), .out_ry(out_ry), .out_rz(out_rz),
    .out_scalar_out(out_scalar_out), .out_compare_flag(out_compare_flag),
    .out_div_zero(out_div_zero), .out_overflow(out_overflow)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic word_t clamp(wide_t v);
    if (v > W_MAX) begin
      fl_ov = 1'b1;
      return word_t'(W_MAX);
    end
    if (v < W_MIN) begin
      fl_ov = 1'b1;
      return word_t'(W_MIN);
    end
    return v[WB-1:0];
  endfunction

  function automatic wide_t prod(word_t a, word_t b);
    return wide_t'(a) * wide_t'(b);
  endfunction

  function automatic word_t fx_mul(word_t a, word_t b);
    return clamp(prod(a, b) >>> FRAC);
  endfunction

  // Quotient truncates toward zero; a zero divisor saturates by the sign of num.
  function automatic word_t fx_div(word_t num, word_t den);
    wide_t nw, dw;
    logic [127:0] n, d, q;
    if (den == 0) begin
      fl_dz = 1'b1;
      return num > 0 ? word_t'(W_MAX) : (num < 0 ? word_t'(W_MIN) : word_t'(0));
    end
    nw = num;
    dw = den;
    n = (nw < 0 ? -nw : nw) << FRAC;
    d = dw < 0 ? -dw : dw;
    q = n / d;
    return clamp(((num < 0) != (den < 0)) ? -wide_t'(q) : wide_t'(q));
  endfunction

  function automatic word_t dot3(word_t a[3], word_t b[3]);
    return clamp((prod(a[0], b[0]) + prod(a[1], b[1]) + prod(a[2], b[2])) >>> FRAC);
  endfunction

  function automatic word_t norm3(word_t a[3]);
    logic [127:0] sum;
    logic [63:0] root, trial;
    sum = prod(a[0], a[0]) + prod(a[1], a[1]) + prod(a[2], a[2]);
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if ({64'd0, trial} * {64'd0, trial} <= sum) root = trial;
    end
    if (root > 64'h7fff_ffff) begin
      fl_ov = 1'b1;
      return word_t'(W_MAX);
    end
    return root[WB-1:0];
  endfunction

  function automatic void cross3(word_t a[3], word_t b[3], output word_t r[3]);
    r[0] = clamp((prod(a[1], b[2]) - prod(a[2], b[1])) >>> FRAC);
    r[1] = clamp((prod(a[2], b[0]) - prod(a[0], b[2])) >>> FRAC);
    r[2] = clamp((prod(a[0], b[1]) - prod(a[1], b[0])) >>> FRAC);
  endfunction

  function automatic alu_result_t evaluate(vec_op_t t);
    alu_result_t res;
    word_t tmp[3];
    word_t nb, p;
    bit bzero;
    fl_ov = 1'b0;
    fl_dz = 1'b0;
    res.r = '{0, 0, 0};
    res.sc = 0;
    res.cmp = 1'b0;
    bzero = t.b[0] == 0 && t.b[1] == 0 && t.b[2] == 0;
    case (t.op)
      OP_ADD:  for (int i = 0; i < 3; i++) res.r[i] = clamp(wide_t'(t.a[i]) + t.b[i]);
      OP_SUB:  for (int i = 0; i < 3; i++) res.r[i] = clamp(wide_t'(t.a[i]) - t.b[i]);
      OP_MUL:  for (int i = 0; i < 3; i++) res.r[i] = fx_mul(t.a[i], t.b[i]);
      OP_SCALE: for (int i = 0; i < 3; i++) res.r[i] = fx_mul(t.a[i], t.s);
      OP_DIV:  for (int i = 0; i < 3; i++) res.r[i] = fx_div(t.a[i], t.b[i]);
      OP_DIVS: for (int i = 0; i < 3; i++) res.r[i] = fx_div(t.a[i], t.s);
      OP_DOT:  res.sc = dot3(t.a, t.b);
      OP_CROSS: cross3(t.a, t.b, res.r);
      OP_NORM: res.sc = norm3(t.a);
      OP_SETLEN: begin
        p = fx_div(t.s, norm3(t.a));
        for (int i = 0; i < 3; i++) res.r[i] = fx_mul(t.a[i], p);
      end
      OP_EQ: res.cmp = t.a[0] == t.b[0] && t.a[1] == t.b[1] && t.a[2] == t.b[2];
      OP_NE: res.cmp = t.a[0] != t.b[0] || t.a[1] != t.b[1] || t.a[2] != t.b[2];
      OP_PAR_SC: begin
        if (bzero) res.sc = norm3(t.a);
        else res.sc = fx_div(dot3(t.a, t.b), norm3(t.b));
      end
      OP_PERP_SC: begin
        if (!bzero) begin
          cross3(t.a, t.b, tmp);
          res.sc = fx_div(norm3(tmp), norm3(t.b));
        end
      end
      default: begin
        // Zero B: the parallel projection passes A through, the other is zero.
        if (bzero) begin
          if (t.op == OP_PAR_VEC) res.r = t.a;
        end else begin
          nb = norm3(t.b);
          p = fx_div(dot3(t.a, t.b), nb);
          for (int i = 0; i < 3; i++) begin
            res.r[i] = fx_mul(fx_div(t.b[i], nb), p);
            if (t.op == OP_PERP_VEC) res.r[i] = clamp(wide_t'(t.a[i]) - res.r[i]);
          end
        end
      end
    endcase
    res.dz = fl_dz;
    res.ov = fl_ov;
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic word_t pick_word();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return 0;
    if (sel < 15) return word_t'(W_MAX);
    if (sel < 20) return word_t'(W_MIN);
    if (sel < 30) begin
      case ($urandom_range(0, 3))
        0: return 1;
        1: return -1;
        2: return 32'sh0001_0000;
        default: return -32'sh0001_0000;
      endcase
    end
    if (sel < 65) return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
    if (sel < 85) return $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
    return word_t'($urandom);
  endfunction

  function automatic int pick_gap(bit quiet);
    int sel;
    if (quiet) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 88) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 100);
  endfunction

  function automatic vec_op_t make_op(op_t op, word_t a[3], word_t b[3], word_t s);
    vec_op_t t;
    t.op = op;
    t.a = a;
    t.b = b;
    t.s = s;
    t.drain_first = 1'b0;
    t.gap_after = pick_gap(1'b0);
    return t;
  endfunction

  task automatic add_random(bit quiet);
    vec_op_t t;
    int k;
    t.op = op_t'($urandom_range(0, 15));
    for (int i = 0; i < 3; i++) begin
      t.a[i] = pick_word();
      t.b[i] = pick_word();
    end
    t.s = pick_word();
    case ($urandom_range(0, 9))
      0: t.b = '{0, 0, 0};
      1: t.a = '{0, 0, 0};
      2: t.b = t.a;
      3: begin
        t.b = t.a;
        k = $urandom_range(0, 2);
        t.b[k] = t.b[k] ^ (word_t'(1) << $urandom_range(0, WB - 1));
      end
      4: t.s = 0;
      default: ;
    endcase
    t.drain_first = $urandom_range(0, 199) == 0;
    t.gap_after = pick_gap(quiet);
    pending_ops.push_back(t);
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    if (!rst_n || pending_ops.size() == 0) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      start <= 1'b0;
    end else if (pending_ops[0].drain_first && expected_results.size() != 0) begin
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      in_op <= pending_ops[0].op;
      in_ax <= pending_ops[0].a[0];
      in_ay <= pending_ops[0].a[1];
      in_az <= pending_ops[0].a[2];
      in_bx <= pending_ops[0].b[0];
      in_by_comp <= pending_ops[0].b[1];
      in_bz <= pending_ops[0].b[2];
      in_scalar_in <= pending_ops[0].s;
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(string name, word_t exp_v, word_t act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    alu_result_t exp_r;
    vec_op_t t;
    if (rst_n) begin
      idle_cycles = idle_cycles + 1;
      if (start && !busy) begin
        t = pending_ops.pop_front();
        expected_results.push_back(evaluate(t));
        gap_left = t.gap_after;
        idle_cycles = 0;
      end
      if (out_valid) begin
        idle_cycles = 0;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result transaction with no expected result", $time);
        end else begin
          exp_r = expected_results.pop_front();
          check_field("rx", exp_r.r[0], out_rx);
          check_field("ry", exp_r.r[1], out_ry);
          check_field("rz", exp_r.r[2], out_rz);
          check_field("scalar_out", exp_r.sc, out_scalar_out);
          check_field("compare_flag", word_t'(exp_r.cmp), word_t'(out_compare_flag));
          check_field("div_zero", word_t'(exp_r.dz), word_t'(out_div_zero));
          check_field("overflow", word_t'(exp_r.ov), word_t'(out_overflow));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_vector3_fixed_point_alu failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    word_t vmax, vmin, one;
    word_t z3[3], big3[3], neg3[3], mix3[3], unit3[3];
    vec_op_t t;
    bit quiet;
    vmax = word_t'(W_MAX);
    vmin = word_t'(W_MIN);
    one = 32'sh0001_0000;
    z3 = '{0, 0, 0};
    big3 = '{vmax, vmax, vmax};
    neg3 = '{vmin, vmin, vmin};
    mix3 = '{vmax, vmin, one};
    unit3 = '{one, 0, 0};
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_ADD;
    {in_ax, in_ay, in_az, in_bx, in_by_comp, in_bz, in_scalar_in} = '0;
    gap_left = 0;
    idle_cycles = 0;
    errors = 0;

    pending_ops.push_back(make_op(OP_ADD, big3, big3, 0));
    pending_ops.push_back(make_op(OP_SUB, neg3, big3, 0));
    pending_ops.push_back(make_op(OP_MUL, mix3, neg3, 0));
    pending_ops.push_back(make_op(OP_SCALE, mix3, z3, vmin));
    pending_ops.push_back(make_op(OP_DIV, '{one, -one, 0}, z3, 0));
    pending_ops.push_back(make_op(OP_DIV, big3, '{1, -1, vmin}, 0));
    pending_ops.push_back(make_op(OP_DIVS, mix3, z3, 0));
    pending_ops.push_back(make_op(OP_DIVS, mix3, z3, 1));
    pending_ops.push_back(make_op(OP_DOT, neg3, neg3, 0));
    pending_ops.push_back(make_op(OP_CROSS, mix3, '{vmin, vmax, vmin}, 0));
    pending_ops.push_back(make_op(OP_NORM, neg3, z3, 0));
    pending_ops.push_back(make_op(OP_SETLEN, z3, z3, one));
    pending_ops.push_back(make_op(OP_SETLEN, unit3, z3, vmax));
    pending_ops.push_back(make_op(OP_EQ, mix3, mix3, 0));
    pending_ops.push_back(make_op(OP_EQ, mix3, '{vmax, vmin, one + 1}, 0));
    pending_ops.push_back(make_op(OP_NE, mix3, '{vmax, vmin, one + 1}, 0));
    pending_ops.push_back(make_op(OP_NE, mix3, mix3, 0));
    pending_ops.push_back(make_op(OP_PAR_SC, mix3, z3, 0));
    pending_ops.push_back(make_op(OP_PAR_SC, big3, '{1, 0, 0}, 0));
    pending_ops.push_back(make_op(OP_PERP_SC, mix3, z3, 0));
    pending_ops.push_back(make_op(OP_PERP_SC, mix3, unit3, 0));
    pending_ops.push_back(make_op(OP_PAR_VEC, mix3, z3, 0));
    pending_ops.push_back(make_op(OP_PAR_VEC, neg3, '{1, 1, 1}, 0));
    pending_ops.push_back(make_op(OP_PERP_VEC, mix3, z3, 0));
    pending_ops.push_back(make_op(OP_PERP_VEC, big3, unit3, 0));
    // Hold the first random transaction until the directed results are all back.
    pending_ops[pending_ops.size() - 1].gap_after = 0;
    for (int blk = 0; blk < 33; blk++) begin
      quiet = $urandom_range(0, 3) == 0;
      for (int i = 0; i < 50; i++) add_random(quiet);
      if (blk == 0) pending_ops[25].drain_first = 1'b1;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_ops.size() == 0 && expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_vector3_fixed_point_alu passed");
    end else begin
      $display("tb_vector3_fixed_point_alu failed");
    end
    $finish;
  end

endmodule
